### src/assert_macros.svh
// Assertion helpers for the heater fire controller checker.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("heater fire controller: assertion failed");

// Same-cycle implication under the clock, off while reset is held.
`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("heater fire controller: implication failed");

`endif

### src/hfc_pkg.sv
// Shared types, register indexes and reset values of the heater fire controller.
// No dependencies; used by hfc_core and heater_fire_controller_unit.
`timescale 1ns / 1ps
`default_nettype none

package hfc_pkg;

  localparam int unsigned FbW    = 12;
  localparam int unsigned DutyW  = 10;
  localparam int unsigned TempW  = 9;
  localparam int unsigned TimerW = 13;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned CfgW   = 13;

  // register indexes
  localparam logic [AddrW-1:0] RegTargetFb   = 3'd0;
  localparam logic [AddrW-1:0] RegDutyMax    = 3'd1;
  localparam logic [AddrW-1:0] RegTempHigh   = 3'd2;
  localparam logic [AddrW-1:0] RegTempLow    = 3'd3;
  localparam logic [AddrW-1:0] RegBurstLimit = 3'd4;

  // reset values
  localparam logic [FbW-1:0]          TargetFbRst   = 12'd0;
  localparam logic [DutyW-1:0]        DutyMaxRst    = 10'd990;
  localparam logic signed [TempW-1:0] TempHighRst   = 9'sd70;
  localparam logic signed [TempW-1:0] TempLowRst    = 9'sd50;
  localparam logic [TimerW-1:0]       BurstLimitRst = 13'd7000;
  localparam logic [TimerW-1:0]       TimerMax      = 13'd8191;

  typedef struct packed {
    logic [FbW-1:0]          target_fb;
    logic [DutyW-1:0]        duty_max;
    logic signed [TempW-1:0] temp_high;
    logic signed [TempW-1:0] temp_low;
    logic [TimerW-1:0]       burst_limit;
  } cfg_t;

  typedef struct packed {
    logic              over_temp;
    logic              low_batt;
    logic [DutyW-1:0]  duty_level;
    logic [TimerW-1:0] burst_timer;
    logic              locked_out;
  } state_t;

  typedef struct packed {
    logic                    ms_tick;
    logic                    batt_low;
    logic signed [TempW-1:0] temperature;
    logic [FbW-1:0]          feedback;
    logic                    fire_pressed;
  } sample_t;

  typedef struct packed {
    logic             burst_timed_out;
    logic [1:0]       status_code;
    logic             firing;
    logic [DutyW-1:0] pwm_duty;
  } result_t;

endpackage

`default_nettype wire

### src/hfc_core.sv
// Per-sample decision logic: status, firing, duty step, burst timer and lock-out.
// Depends on hfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfc_core (
  input  hfc_pkg::cfg_t    cfg_i,
  input  hfc_pkg::state_t  state_i,
  input  hfc_pkg::sample_t sample_i,
  output hfc_pkg::state_t  state_o,
  output hfc_pkg::result_t result_o
);

  logic       ot;
  logic       lb;
  logic [1:0] status;

  always_comb begin
    ot = state_i.over_temp;
    if (sample_i.temperature > cfg_i.temp_high) ot = 1'b1;
    // clear wins when the limits are set crosswise
    if (sample_i.temperature < cfg_i.temp_low) ot = 1'b0;
    lb     = state_i.low_batt | sample_i.batt_low;
    status = {ot, lb};
  end

  always_comb begin
    state_o           = state_i;
    state_o.over_temp = ot;
    state_o.low_batt  = lb;
    result_o          = '0;

    if (!sample_i.fire_pressed) begin
      state_o.burst_timer = '0;
      state_o.locked_out  = 1'b0;
    end else if (state_i.locked_out) begin
      // hold until release
    end else if (status != 2'b00) begin
      state_o.burst_timer = '0;
    end else if (state_i.burst_timer >= cfg_i.burst_limit) begin
      state_o.locked_out = 1'b1;
    end else begin
      result_o.firing   = 1'b1;
      result_o.pwm_duty = state_i.duty_level;
      if (sample_i.feedback > cfg_i.target_fb && state_i.duty_level != '0) begin
        state_o.duty_level = state_i.duty_level - 1'b1;
      end else if (sample_i.feedback < cfg_i.target_fb &&
                   state_i.duty_level < cfg_i.duty_max) begin
        state_o.duty_level = state_i.duty_level + 1'b1;
      end
      if (sample_i.ms_tick && state_i.burst_timer != hfc_pkg::TimerMax) begin
        state_o.burst_timer = state_i.burst_timer + 1'b1;
      end
    end

    result_o.status_code     = status;
    result_o.burst_timed_out = state_o.locked_out;
  end

endmodule

`default_nettype wire

### src/heater_fire_controller_unit.sv
// Heater fire controller top level: config registers, state, output buffer.
// Depends on hfc_pkg and hfc_core.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - s_axis carries one sample per transaction (button, feedback code, coil
//   temperature, low-battery pin, ms tick). m_axis returns exactly one result
//   per sample, in order: duty, firing flag, status and lock-out flag.
// - The whole decision is worked out in the cycle of acceptance, straight from
//   the sample and the held state, and is registered in the output register,
//   or in the skid register while an earlier result waits to be taken.
// - Throughput is one sample per cycle while the buffer has room; the state
//   update is a single compare and +/-1 step, so samples chain with no gap.
// - A two-entry output buffer (output register plus skid register) lets a new
//   sample in while a result waits. s_axis_tready drops only when both are
//   full, i.e. after the receiver has stalled for two results.
// - The cfg port writes one register per cycle with cfg_we_i high; indexes
//   beyond the list are ignored. Write only while the block is idle.
// - Reset (rst_ni low, asynchronous) clears the flags, duty level, burst timer
//   and lock-out, empties the buffer and loads the register defaults
//   (target 0, duty max 990, high 70 C, low 50 C, burst limit 7000 ms).

module heater_fire_controller_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [12:0] cfg_wdata_i,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] fire_pressed, [12:1] feedback, [21:13] temperature,
  // [22] batt_low, [23] ms_tick
  input  wire logic [23:0] s_axis_tdata,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [9:0] pwm_duty, [10] firing, [12:11] status_code,
  // [13] burst_timed_out, [15:14] zero
  output logic [15:0]      m_axis_tdata
);

  hfc_pkg::cfg_t    cfg_q;
  hfc_pkg::state_t  state_q, state_d;
  hfc_pkg::sample_t sample;
  hfc_pkg::result_t result;

  hfc_pkg::result_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;
  logic             in_acc, out_take;

  assign sample   = hfc_pkg::sample_t'(s_axis_tdata);
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_take = m_axis_tvalid & m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_fb   <= hfc_pkg::TargetFbRst;
      cfg_q.duty_max    <= hfc_pkg::DutyMaxRst;
      cfg_q.temp_high   <= hfc_pkg::TempHighRst;
      cfg_q.temp_low    <= hfc_pkg::TempLowRst;
      cfg_q.burst_limit <= hfc_pkg::BurstLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        hfc_pkg::RegTargetFb:   cfg_q.target_fb   <= cfg_wdata_i[11:0];
        hfc_pkg::RegDutyMax:    cfg_q.duty_max    <= cfg_wdata_i[9:0];
        hfc_pkg::RegTempHigh:   cfg_q.temp_high   <= $signed(cfg_wdata_i[8:0]);
        hfc_pkg::RegTempLow:    cfg_q.temp_low    <= $signed(cfg_wdata_i[8:0]);
        hfc_pkg::RegBurstLimit: cfg_q.burst_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hfc_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .sample_i (sample),
    .state_o  (state_d),
    .result_o (result)
  );

  // controller state advances once per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // output register plus skid register
  assign s_axis_tready = ~skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (!out_valid_q) begin
      out_valid_q <= in_acc;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_acc && (out_take || !out_valid_q)) begin
      out_q <= result;
    end
    if (in_acc && out_valid_q && !out_take) begin
      skid_q <= result;
    end
  end

endmodule

`default_nettype wire

### src/hfc_checker.sv
// Port-level checks for heater_fire_controller_unit, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hfc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  logic       out_fire;
  logic [9:0] out_duty;
  logic [2:0] out_flags;
  logic       out_stall;

  assign out_fire  = m_axis_tdata[10];
  assign out_duty  = m_axis_tdata[9:0];
  assign out_flags = m_axis_tdata[13:11];
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // no duty is driven outside a burst
  `ASSERT_IMPL(a_duty_zero_idle, clk_i, rst_ni, m_axis_tvalid && !out_fire, out_duty == 10'd0)
  // firing only with clear status and no lock-out
  `ASSERT_IMPL(a_fire_clear, clk_i, rst_ni, m_axis_tvalid && out_fire, out_flags == 3'b000)
  // input stalls only when a result is pending
  `ASSERT_IMPL(a_stall_pending, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)
  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind heater_fire_controller_unit hfc_checker u_hfc_checker (.*);

`default_nettype wire

### tb/sv/heater_fire_controller_unit_tb.sv
// Self-checking bench for heater_fire_controller_unit: directed and random samples,
// with a per-sample predictor of the fire decision. Depends on hfc_pkg and the RTL.
`timescale 1ns / 1ps

module heater_fire_controller_unit_tb;
  import hfc_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input holds a known value from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_addr_i    = '0;
  logic [12:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] fire_pressed, [12:1] feedback, [21:13] temperature,
  // [22] batt_low, [23] ms_tick
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [9:0] pwm_duty, [10] firing, [12:11] status_code,
  // [13] burst_timed_out, [15:14] zero
  logic [15:0] m_axis_tdata;

  localparam int QuietLimit = 4000;  // cycles with no transaction on either side
  localparam int HoldCycles = 150;   // long receiver hold-off

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  heater_fire_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers and the controller state
  // ---------------------------------------------------------------------------
  logic [FbW-1:0]          fb_goal      = TargetFbRst;
  logic [DutyW-1:0]        duty_ceiling = DutyMaxRst;
  logic signed [TempW-1:0] hot_limit    = TempHighRst;
  logic signed [TempW-1:0] cool_limit   = TempLowRst;
  logic [TimerW-1:0]       burst_cap    = BurstLimitRst;

  logic              heat_flag = 1'b0;
  logic              batt_flag = 1'b0;
  logic [DutyW-1:0]  duty_now  = '0;
  logic [TimerW-1:0] burst_ms  = '0;
  logic              lockout   = 1'b0;

  sample_t pending_samples[$];   // waiting to be offered
  result_t expected_results[$];  // predicted, not yet seen on m_axis

  int n_errors  = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_fired   = 0;
  int n_locked  = 0;
  int n_hot     = 0;
  int n_batt    = 0;
  int n_blocked = 0;  // cycles with s_axis held off by the block
  int tick_pct  = 50;

  // One sample through the controller. Status is formed after the flag updates,
  // and the fire decision then uses that status.
  function automatic result_t predict_result(sample_t s);
    result_t    r;
    logic [1:0] status;
    r = '0;
    if ($signed(s.temperature) > hot_limit) heat_flag = 1'b1;
    // crosswise limits: the clear is applied last, so it wins
    if ($signed(s.temperature) < cool_limit) heat_flag = 1'b0;
    if (s.batt_low) batt_flag = 1'b1;
    status = {heat_flag, batt_flag};
    if (!s.fire_pressed) begin
      burst_ms = '0;
      lockout  = 1'b0;
    end else if (lockout) begin
      // timed out: nothing until the button is let go
    end else if (status != 2'b00) begin
      burst_ms = '0;
    end else if (burst_ms >= burst_cap) begin
      lockout = 1'b1;
    end else begin
      r.firing   = 1'b1;
      r.pwm_duty = duty_now;
      if (s.feedback > fb_goal && duty_now != '0) duty_now = duty_now - 1'b1;
      // above a lowered ceiling the duty is kept, it just stops rising
      if (s.feedback < fb_goal && duty_now < duty_ceiling) duty_now = duty_now + 1'b1;
      if (s.ms_tick && burst_ms != TimerMax) burst_ms = burst_ms + 1'b1;
    end
    r.status_code     = status;
    r.burst_timed_out = lockout;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; prediction on acceptance
  // ---------------------------------------------------------------------------
  sample_t on_bus;
  int      burst_left = 1;
  int      gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_result(on_bus));
        n_samples++;
      end
      if (s_axis_tvalid && !s_axis_tready) n_blocked++;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          on_bus = pending_samples.pop_front();
          s_axis_tdata  <= on_bus;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
            gap_left   = ($urandom_range(3) == 0) ? $urandom_range(4, 20)
                                                  : $urandom_range(0, 3);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each result transaction, drives the receiver stalls
  // ---------------------------------------------------------------------------
  int rx_cycle  = 0;
  int hold_left = 0;

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[13:0]);
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0t ns: unexpected result, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          compare_field("pwm_duty", want.pwm_duty, got.pwm_duty);
          compare_field("firing", want.firing, got.firing);
          compare_field("status_code", want.status_code, got.status_code);
          compare_field("burst_timed_out", want.burst_timed_out, got.burst_timed_out);
          compare_field("tdata padding", 0, m_axis_tdata[15:14]);
          if (want.firing) n_fired++;
          if (want.burst_timed_out) n_locked++;
          if (want.status_code[1]) n_hot++;
          if (want.status_code[0]) n_batt++;
        end
        n_results++;
        // long hold-offs so the skid buffer fills and s_axis backs up
        if (n_results == 500 || n_results == 1400) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((rx_cycle >> 8) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(3) != 0);
          2:       m_axis_tready <= ($urandom_range(1) != 0);
          default: m_axis_tready <= ((rx_cycle % 7) < 3);
        endcase
      end
      rx_cycle++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no transaction on either side ends the run
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_sample(input bit pressed, input int fb, input int temp,
                             input bit lowb, input bit tick);
    sample_t s;
    s.fire_pressed = pressed;
    s.feedback     = fb[FbW-1:0];
    s.temperature  = temp[TempW-1:0];
    s.batt_low     = lowb;
    s.ms_tick      = tick;
    pending_samples.push_back(s);
  endtask

  // One register per clock; the bench copy changes with it (block is idle)
  task automatic write_reg(input logic [AddrW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegTargetFb:   fb_goal      = val[FbW-1:0];
      RegDutyMax:    duty_ceiling = val[DutyW-1:0];
      RegTempHigh:   hot_limit    = val[TempW-1:0];
      RegTempLow:    cool_limit   = val[TempW-1:0];
      RegBurstLimit: burst_cap    = val[TimerW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input int goal, input int ceiling, input int hot,
                            input int cool, input int cap);
    write_reg(RegTargetFb, CfgW'(goal));
    write_reg(RegDutyMax, CfgW'(ceiling));
    write_reg(RegTempHigh, CfgW'(hot));
    write_reg(RegTempLow, CfgW'(cool));
    write_reg(RegBurstLimit, CfgW'(cap));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Every sample gives a result, so once both queues are empty and s_axis is
  // quiet, the block is idle.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic int rand_between(input int lo, input int hi);
    return (hi <= lo) ? lo : lo + int'($urandom_range(hi - lo));
  endfunction

  // Mostly held presses with safe temperatures, feedback near the goal half the time;
  // the rest is hot spikes, stray button bits and extreme or random codes.
  task automatic random_phase(input int n, input bit batt_ok);
    int  left;
    int  run;
    int  span;
    int  fb;
    int  temp;
    bit  pressed;
    bit  lowb;
    left = n;
    span = (int'(burst_cap) > 200) ? 400 : 2 * int'(burst_cap) + 30;
    while (left > 0) begin
      run = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : rand_between(5, span);
      for (int i = 0; i < run + int'($urandom_range(1, 4)) && left > 0; i++) begin
        pressed = (i < run);
        if ($urandom_range(9) == 0) pressed = ($urandom_range(1) != 0);
        case ($urandom_range(3))
          0:       fb = $urandom_range(4095);
          1:       fb = $urandom_range(1) ? 4095 : 0;
          default: fb = rand_between(int'(fb_goal) - 3, int'(fb_goal) + 3);
        endcase
        if (fb < 0) fb = 0;
        if (fb > 4095) fb = 4095;
        if ($urandom_range(99) < 85) temp = rand_between(-40, int'(hot_limit));
        else                         temp = rand_between(-40, 150);
        // the battery latch is sticky, so it only comes late in the last phase
        lowb = batt_ok && (left < n / 4) && ($urandom_range(49) == 0);
        push_sample(pressed, fb, temp, lowb, $urandom_range(99) < tick_pct);
        left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int goal;
    int ceiling;
    int hot;
    int cool;
    int cap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: fire, duty floor, hysteresis band and its edges
    push_sample(0, 0, 0, 0, 0);
    push_sample(1, 4095, -40, 0, 1);
    push_sample(1, 0, 150, 0, 1);
    push_sample(1, 0, 60, 0, 0);
    push_sample(1, 0, 49, 0, 0);
    push_sample(1, 0, 70, 0, 0);
    push_sample(1, 0, 71, 0, 1);
    push_sample(0, 4095, -40, 0, 0);
    wait_drained();

    // zero burst limit: locks on the first held sample, release unlocks
    set_limits(4095, 1023, 150, -40, 0);
    push_sample(1, 0, 0, 0, 1);
    push_sample(1, 0, 0, 0, 0);
    push_sample(0, 0, 0, 0, 0);
    wait_drained();

    // crosswise limits, duty saturating at a small ceiling, time-out
    set_limits(2048, 3, 40, 60, 2);
    push_sample(1, 0, 50, 0, 1);
    push_sample(1, 0, 30, 0, 1);
    push_sample(1, 0, 30, 0, 0);
    push_sample(0, 0, 30, 0, 0);
    push_sample(1, 0, 30, 0, 0);
    push_sample(1, 0, 30, 0, 0);
    push_sample(1, 0, 30, 0, 0);
    push_sample(1, 2048, 30, 0, 0);
    wait_drained();

    // ceiling lowered under the current duty: kept, steps down, no rise
    set_limits(2048, 1, 40, 60, 8191);
    push_sample(1, 4095, 30, 0, 0);
    push_sample(1, 0, 30, 0, 0);
    push_sample(1, 0, 61, 0, 0);
    push_sample(1, 0, -40, 0, 0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        // long climb towards full duty, no time-out reachable
        set_limits(4095, 1023, 150, -40, 8191);
        tick_pct = 10;
      end else begin
        case ($urandom_range(3))
          0:       goal = 0;
          1:       goal = 4095;
          default: goal = $urandom_range(4095);
        endcase
        case ($urandom_range(3))
          0:       ceiling = 0;
          1:       ceiling = 1023;
          default: ceiling = $urandom_range(1023);
        endcase
        hot  = rand_between(-40, 150);
        cool = ($urandom_range(4) == 0) ? rand_between(-40, 150) : rand_between(-40, hot);
        case ($urandom_range(7))
          0:       cap = 0;
          1:       cap = 8191;
          default: cap = $urandom_range(1, 60);
        endcase
        set_limits(goal, ceiling, hot, cool, cap);
        tick_pct = $urandom_range(20, 100);
      end
      random_phase(240, p == 7);
      wait_drained();
    end

    // battery latch stays set after the pin drops
    push_sample(1, 0, 0, 1, 0);
    push_sample(1, 0, 0, 0, 0);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d samples / %0d results: %0d firing, %0d locked out,",
             n_samples, n_results, n_fired, n_locked);
    $display("%0d hot, %0d low batt; input held off by the block for %0d cycles; %0d mismatches",
             n_hot, n_batt, n_blocked, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/hfc_pkg.sv
src/hfc_core.sv
src/heater_fire_controller_unit.sv
src/hfc_checker.sv
tb/sv/heater_fire_controller_unit_tb.sv
